// File: sv/arcade_tank_drive_mixer_defines.svh
// assertion macros for the arcade/tank drive mixer
// no dependencies; included by files that carry concurrent checks
`ifndef ARCADE_TANK_DRIVE_MIXER_DEFINES_SVH
`define ARCADE_TANK_DRIVE_MIXER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define ATDM_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("arcade_tank_drive_mixer: check failed");

// next-cycle implication, disabled while reset is high
`define ATDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("arcade_tank_drive_mixer: check failed");

`endif

// File: sv/atdm_pkg.sv
// shared widths, constants and types for the arcade/tank drive mixer
// no dependencies; imported by every module of the block
package atdm_pkg;

   // field widths
   localparam int RAW_W   = 8;
   localparam int MAG_W   = 7;
   localparam int SPEED_W = 7;
   localparam int MIX_W   = 8;
   localparam int DRIVE_W = 8;
   localparam int LANES   = 2;

   // fixed scale constants
   localparam int FULL_SWING = 127;
   localparam int TANK_DIV   = 254;

   // divider shapes: stick rescale and final speed scale
   localparam int NUM1_W = 2 * MAG_W;
   localparam int DIV1_W = MAG_W;
   localparam int NUM2_W = MIX_W + SPEED_W;
   localparam int DIV2_W = MIX_W;
   localparam int QUO_W  = MAG_W;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_STICK_DEADZONE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_THRESHOLD = 1'd1;
   localparam logic [MAG_W-1:0] DEADZONE_RESET  = 7'd5;
   localparam logic [MAG_W-1:0] THRESHOLD_RESET = 7'h40;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // request payload, first field in the highest bits
   typedef struct packed {
      logic [RAW_W-1:0] mode_knob;
      logic [RAW_W-1:0] speed_knob;
      logic [RAW_W-1:0] left_stick_x;
      logic [RAW_W-1:0] left_stick_y;
      logic [RAW_W-1:0] right_stick_y;
      logic [RAW_W-1:0] right_stick_x;
   } atdm_req_fields_type;

   // response payload, first field in the highest bits
   typedef struct packed {
      logic signed [DRIVE_W-1:0] right_drive;
      logic signed [DRIVE_W-1:0] left_drive;
   } atdm_rsp_fields_type;

   // centered stick with deadzone removed, sign and magnitude
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } atdm_stick_type;

   // classified frame as queued between front and back
   typedef struct packed {
      logic                 arcade;
      atdm_stick_type       stick_a;
      atdm_stick_type       stick_b;
      logic [SPEED_W-1:0]   speed;
   } atdm_item_type;

   // side data carried through the stick rescale divider
   typedef struct packed {
      logic               arcade;
      logic               a_neg;
      logic               b_neg;
      logic [SPEED_W-1:0] speed;
   } atdm_mix_sb_type;

   // side data carried through the speed scale divider
   typedef struct packed {
      logic left_neg;
      logic right_neg;
   } atdm_sign_sb_type;

   // queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } atdm_queue_status_type;

endpackage

// File: sv/atdm_queue.sv
// small register queue that decouples the classifying front from the back
// depends on atdm_pkg for the item type
module atdm_queue
   import atdm_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  atdm_item_type         push_item,
   input  logic                  pop,
   output atdm_item_type         head_item,
   output atdm_queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   atdm_item_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// File: sv/atdm_front.sv
// front end: takes a frame, centers channels, decodes the mix mode and
// queues the classified frame; depends on atdm_pkg
module atdm_front
   import atdm_pkg::*;
(
   input  logic                  req_valid,
   output logic                  req_ready,
   input  atdm_req_fields_type   req_fields,
   input  logic [MAG_W-1:0]      deadzone,
   input  logic [MAG_W-1:0]      threshold,
   input  atdm_queue_status_type q_status,
   output logic                  q_push,
   output atdm_item_type         q_item
);

   // center a raw channel and strip the deadzone, sign and magnitude
   function automatic atdm_stick_type center_stick(input logic [RAW_W-1:0] raw,
                                                   input logic [MAG_W-1:0] dz);
      logic [MAG_W-1:0] span;
      atdm_stick_type   res;
      span    = raw[RAW_W-1] ? raw[MAG_W-1:0] : ~raw[MAG_W-1:0];
      res.neg = ~raw[RAW_W-1];
      res.mag = (span > dz) ? span - dz : '0;
      return res;
   endfunction

   logic [MAG_W-1:0] mode_dist;
   logic             arcade;
   logic             left_side;
   logic [RAW_W-1:0] a_raw;
   logic [RAW_W-1:0] b_raw;

   // mode knob: low side right-stick arcade, high side left-stick arcade
   assign mode_dist = req_fields.mode_knob[RAW_W-1] ? req_fields.mode_knob[MAG_W-1:0]
                                                    : ~req_fields.mode_knob[MAG_W-1:0];
   assign arcade    = mode_dist > threshold;
   assign left_side = req_fields.mode_knob[RAW_W-1];

   // lane a is the throttle (arcade) or left track (tank), lane b steer or right track
   always_comb begin
      if (!arcade) begin
         a_raw = req_fields.left_stick_y;
         b_raw = req_fields.right_stick_y;
      end else if (left_side) begin
         a_raw = req_fields.left_stick_y;
         b_raw = req_fields.left_stick_x;
      end else begin
         a_raw = req_fields.right_stick_y;
         b_raw = req_fields.right_stick_x;
      end
   end

   assign q_item.arcade  = arcade;
   assign q_item.stick_a = center_stick(a_raw, deadzone);
   assign q_item.stick_b = center_stick(b_raw, deadzone);
   assign q_item.speed   = req_fields.speed_knob[RAW_W-1:1];

   // transfer while the queue has room
   assign req_ready = ~q_status.full;
   assign q_push    = req_valid & req_ready;

endmodule

// File: sv/atdm_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor; depends on atdm_pkg for default widths
module atdm_div_pipe
   import atdm_pkg::*;
#(
   parameter int LANE_N = LANES,
   parameter int NUM_W  = NUM1_W,
   parameter int DIV_W  = DIV1_W,
   parameter int Q_W    = QUO_W,
   parameter int SB_W   = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [LANE_N-1:0][NUM_W-1:0]  in_num,
   input  logic [DIV_W-1:0]              in_div,
   input  logic [SB_W-1:0]               in_sb,
   output logic                          out_valid,
   output logic [LANE_N-1:0][Q_W-1:0]    out_quo,
   output logic [SB_W-1:0]               out_sb
);

   // wide enough for the divisor shifted to the top quotient bit
   localparam int CW = DIV_W + Q_W;

   logic             valid_ff [Q_W];
   logic [NUM_W-1:0] rem_ff   [Q_W][LANE_N];
   logic [Q_W-1:0]   quo_ff   [Q_W][LANE_N];
   logic [DIV_W-1:0] div_ff   [Q_W];
   logic [SB_W-1:0]  sb_ff    [Q_W];

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      localparam int BIT = Q_W - 1 - s;

      logic             prv_valid;
      logic [NUM_W-1:0] prv_rem [LANE_N];
      logic [Q_W-1:0]   prv_quo [LANE_N];
      logic [DIV_W-1:0] prv_div;
      logic [SB_W-1:0]  prv_sb;
      logic [CW-1:0]    dsh;
      logic [NUM_W-1:0] rem_in  [LANE_N];
      logic [Q_W-1:0]   quo_in  [LANE_N];

      // stage inputs: the port for the first stage, the previous stage after
      if (s == 0) begin : g_first
         assign prv_valid = in_valid;
         assign prv_div   = in_div;
         assign prv_sb    = in_sb;
         always_comb begin
            for (int l = 0; l < LANE_N; l++) begin
               prv_rem[l] = in_num[l];
               prv_quo[l] = '0;
            end
         end
      end else begin : g_next
         assign prv_valid = valid_ff[s-1];
         assign prv_div   = div_ff[s-1];
         assign prv_sb    = sb_ff[s-1];
         always_comb begin
            for (int l = 0; l < LANE_N; l++) begin
               prv_rem[l] = rem_ff[s-1][l];
               prv_quo[l] = quo_ff[s-1][l];
            end
         end
      end

      assign dsh = CW'(prv_div) << BIT;

      // trial subtract per lane
      for (genvar l = 0; l < LANE_N; l++) begin : g_lane
         logic [CW-1:0] rem_ext;
         logic          take;
         assign rem_ext   = CW'(prv_rem[l]);
         assign take      = rem_ext >= dsh;
         assign rem_in[l] = take ? NUM_W'(rem_ext - dsh) : prv_rem[l];
         assign quo_in[l] = prv_quo[l] | (Q_W'(take) << BIT);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= prv_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[s] <= prv_div;
            sb_ff[s]  <= prv_sb;
            for (int l = 0; l < LANE_N; l++) begin
               rem_ff[s][l] <= rem_in[l];
               quo_ff[s][l] <= quo_in[l];
            end
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_sb    = sb_ff[Q_W-1];

   always_comb begin
      for (int l = 0; l < LANE_N; l++) begin
         out_quo[l] = quo_ff[Q_W-1][l];
      end
   end

endmodule

// File: sv/atdm_back.sv
// back end: stick rescale divider, arcade/tank mix, speed scale divider
// and the output register; depends on atdm_pkg and atdm_div_pipe
module atdm_back
   import atdm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [MAG_W-1:0]      deadzone,
   input  atdm_item_type         q_item,
   input  atdm_queue_status_type q_status,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output atdm_rsp_fields_type   rsp_fields
);

   logic en;

   // whole back pipeline advances while the output register can take a transfer
   assign en    = ~rsp_valid | rsp_ready;
   assign q_pop = en & ~q_status.empty;

   // numerator and divisor for the stick rescale
   logic                          s0_valid_ff;
   logic [LANES-1:0][NUM1_W-1:0]  s0_num_ff;
   logic [DIV1_W-1:0]             s0_div_ff;
   atdm_mix_sb_type               s0_sb_ff;
   logic [DIV1_W-1:0]             rescale_div;

   // a full deadzone leaves all sticks at zero; keep the divisor nonzero
   assign rescale_div = (deadzone == DIV1_W'(FULL_SWING)) ? DIV1_W'(1)
                                                          : DIV1_W'(FULL_SWING) - deadzone;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= ~q_status.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_num_ff[0]      <= NUM1_W'(q_item.stick_a.mag) * NUM1_W'(FULL_SWING);
         s0_num_ff[1]      <= NUM1_W'(q_item.stick_b.mag) * NUM1_W'(FULL_SWING);
         s0_div_ff         <= rescale_div;
         s0_sb_ff.arcade   <= q_item.arcade;
         s0_sb_ff.a_neg    <= q_item.stick_a.neg;
         s0_sb_ff.b_neg    <= q_item.stick_b.neg;
         s0_sb_ff.speed    <= q_item.speed;
      end
   end

   // stick rescale: magnitude * 127 / (127 - deadzone)
   logic                         d1_valid;
   logic [LANES-1:0][QUO_W-1:0]  d1_quo;
   logic [$bits(atdm_mix_sb_type)-1:0] d1_sb_bits;
   atdm_mix_sb_type              d1_sb;

   atdm_div_pipe #(
      .LANE_N (LANES),
      .NUM_W  (NUM1_W),
      .DIV_W  (DIV1_W),
      .Q_W    (QUO_W),
      .SB_W   ($bits(atdm_mix_sb_type))
   ) u_rescale_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_valid_ff),
      .in_num    (s0_num_ff),
      .in_div    (s0_div_ff),
      .in_sb     (s0_sb_ff),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_sb    (d1_sb_bits)
   );

   assign d1_sb = atdm_mix_sb_type'(d1_sb_bits);

   // arcade mix: left = y - x, right = y + x, divisor max(|l|, |r|, 127)
   logic signed [MIX_W:0] y_s, x_s, lv_s, rv_s;
   logic [MIX_W-1:0]      lv_mag, rv_mag, peak;
   logic [MIX_W-1:0]      mix_mag1, mix_mag2, mix_div;
   logic                  mix_neg1, mix_neg2;

   always_comb begin
      y_s    = d1_sb.a_neg ? -$signed({2'b00, d1_quo[0]}) : $signed({2'b00, d1_quo[0]});
      x_s    = d1_sb.b_neg ? -$signed({2'b00, d1_quo[1]}) : $signed({2'b00, d1_quo[1]});
      lv_s   = y_s - x_s;
      rv_s   = y_s + x_s;
      lv_mag = lv_s[MIX_W] ? MIX_W'(-lv_s) : lv_s[MIX_W-1:0];
      rv_mag = rv_s[MIX_W] ? MIX_W'(-rv_s) : rv_s[MIX_W-1:0];
      peak   = (lv_mag > rv_mag) ? lv_mag : rv_mag;
      if (peak < MIX_W'(FULL_SWING)) begin
         peak = MIX_W'(FULL_SWING);
      end
      if (d1_sb.arcade) begin
         mix_mag1 = lv_mag;
         mix_neg1 = lv_s[MIX_W];
         mix_mag2 = rv_mag;
         mix_neg2 = rv_s[MIX_W];
         mix_div  = peak;
      end else begin
         mix_mag1 = MIX_W'(d1_quo[0]);
         mix_neg1 = d1_sb.a_neg;
         mix_mag2 = MIX_W'(d1_quo[1]);
         mix_neg2 = d1_sb.b_neg;
         mix_div  = MIX_W'(TANK_DIV);
      end
   end

   logic                mx_valid_ff;
   logic [MIX_W-1:0]    mx_mag1_ff, mx_mag2_ff, mx_div_ff;
   atdm_sign_sb_type    mx_sign_ff;
   logic [SPEED_W-1:0]  mx_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mx_valid_ff <= 1'b0;
      end else if (en) begin
         mx_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_mag1_ff           <= mix_mag1;
         mx_mag2_ff           <= mix_mag2;
         mx_div_ff            <= mix_div;
         mx_sign_ff.left_neg  <= mix_neg1;
         mx_sign_ff.right_neg <= mix_neg2;
         mx_speed_ff          <= d1_sb.speed;
      end
   end

   // scale by speed
   logic                          ml_valid_ff;
   logic [LANES-1:0][NUM2_W-1:0]  ml_num_ff;
   logic [DIV2_W-1:0]             ml_div_ff;
   atdm_sign_sb_type              ml_sign_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ml_valid_ff <= 1'b0;
      end else if (en) begin
         ml_valid_ff <= mx_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ml_num_ff[0] <= NUM2_W'(mx_mag1_ff) * NUM2_W'(mx_speed_ff);
         ml_num_ff[1] <= NUM2_W'(mx_mag2_ff) * NUM2_W'(mx_speed_ff);
         ml_div_ff    <= mx_div_ff;
         ml_sign_ff   <= mx_sign_ff;
      end
   end

   // magnitude * speed / divisor, truncated toward zero
   logic                         d2_valid;
   logic [LANES-1:0][QUO_W-1:0]  d2_quo;
   logic [$bits(atdm_sign_sb_type)-1:0] d2_sb_bits;
   atdm_sign_sb_type             d2_sign;

   atdm_div_pipe #(
      .LANE_N (LANES),
      .NUM_W  (NUM2_W),
      .DIV_W  (DIV2_W),
      .Q_W    (QUO_W),
      .SB_W   ($bits(atdm_sign_sb_type))
   ) u_speed_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ml_valid_ff),
      .in_num    (ml_num_ff),
      .in_div    (ml_div_ff),
      .in_sb     (ml_sign_ff),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_sb    (d2_sb_bits)
   );

   assign d2_sign = atdm_sign_sb_type'(d2_sb_bits);

   // apply signs, right track negated for mirrored wiring
   logic signed [DRIVE_W-1:0] left_pos, right_pos;
   logic                      rsp_valid_ff;
   atdm_rsp_fields_type       rsp_data_ff;

   assign left_pos  = $signed(DRIVE_W'(d2_quo[0]));
   assign right_pos = $signed(DRIVE_W'(d2_quo[1]));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff.left_drive  <= d2_sign.left_neg  ? -left_pos  : left_pos;
         rsp_data_ff.right_drive <= d2_sign.right_neg ? right_pos  : -right_pos;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_fields = rsp_data_ff;

endmodule

// File: sv/arcade_tank_drive_mixer.sv
// Arcade/tank drive mixer: one frame of six raw radio channels in, one pair of
// signed track drive values out, for every frame. A new frame is taken every
// clock cycle while the consumer keeps up; each result passes the queue write,
// the numerator register, two 7-stage restoring dividers (stick rescale and
// speed scale, one quotient bit per stage) and the mix, multiply and output
// stages. A 4-entry queue separates the classifying front from the arithmetic
// back, so input transfers continue while the output stalls, until the queue
// fills. Users write registers only while idle; the block does not enforce it.
`include "arcade_tank_drive_mixer_defines.svh"

module arcade_tank_drive_mixer
   import atdm_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request: right_stick_x, right_stick_y, left_stick_y, left_stick_x,
   // speed_knob, mode_knob (8 bits each, from bit 0 up)
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [$bits(atdm_req_fields_type)-1:0] req_tdata,
   // response: left_drive, right_drive (8 bits signed each, from bit 0 up)
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [$bits(atdm_rsp_fields_type)-1:0] rsp_tdata,
   // register writes
   input  logic                                   csr_wen,
   input  logic [CSR_IDX_W-1:0]                   csr_index,
   input  logic [CSR_DATA_W-1:0]                  csr_wdata
);

   // configuration registers
   logic [MAG_W-1:0] deadzone_ff, deadzone_in;
   logic [MAG_W-1:0] threshold_ff, threshold_in;

   always_comb begin
      deadzone_in  = deadzone_ff;
      threshold_in = threshold_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_STICK_DEADZONE: deadzone_in  = MAG_W'(csr_wdata);
            CSR_MODE_THRESHOLD: threshold_in = MAG_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff  <= DEADZONE_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         deadzone_ff  <= deadzone_in;
         threshold_ff <= threshold_in;
      end
   end

   // front, queue, back
   atdm_req_fields_type   req_fields;
   atdm_rsp_fields_type   rsp_fields;
   atdm_item_type         q_item_in;
   atdm_item_type         q_head;
   atdm_queue_status_type q_status;
   logic                  q_push;
   logic                  q_pop;

   assign req_fields = atdm_req_fields_type'(req_tdata);
   assign rsp_tdata  = rsp_fields;

   atdm_front u_front (
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_fields (req_fields),
      .deadzone   (deadzone_ff),
      .threshold  (threshold_ff),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_item     (q_item_in)
   );

   atdm_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item_in),
      .pop       (q_pop),
      .head_item (q_head),
      .status    (q_status)
   );

   atdm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .deadzone   (deadzone_ff),
      .q_item     (q_head),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_fields (rsp_fields)
   );

   // most negative code never appears on either track
   localparam logic [DRIVE_W-1:0] DRIVE_NEG_LIMIT = {1'b1, {(DRIVE_W-1){1'b0}}};

   logic drive_in_range;

   assign drive_in_range = (rsp_fields.left_drive != DRIVE_NEG_LIMIT) &&
                           (rsp_fields.right_drive != DRIVE_NEG_LIMIT);

   // checks
   `ATDM_ASSERT(a_drive_in_range, clock, reset, rsp_tvalid, drive_in_range)
   `ATDM_ASSERT(a_no_pop_on_stall, clock, reset, rsp_tvalid && !rsp_tready, !q_pop)
   `ATDM_ASSERT(a_no_push_when_full, clock, reset, q_status.full, !q_push)
   `ATDM_ASSERT_NEXT(a_empty_stays, clock, reset, q_status.empty && !q_push, q_status.empty)

endmodule
